// ===== hdl/psda_pkg.sv =====
// Package for the phase-space density accumulator.
// Request and result structs, table and skip-list constants, command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psda_pkg;
  localparam int TableSize = 64;
  localparam int MaxSkip = 4;
  localparam int TIdxW = $clog2(TableSize);
  localparam int SkipCntW = $clog2(MaxSkip + 1);
  localparam int SkipIdxW = $clog2(MaxSkip);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_SKIP  = 2'd2,
    CMD_PART  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_MOM_RADIUS = 2'd0;
  localparam logic [1:0] REG_CUTOFF     = 2'd1;
  localparam logic [1:0] REG_TEST_PART  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic signed [31:0] species;
    logic [30:0]        ident;
    logic [31:0]        weight_value;
    logic               last;
  } req_t;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
  } res_t;

  // control from sequencer to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_res_t;
endpackage
`default_nettype wire

// ===== hdl/psda_div.sv =====
// Radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle.
// Depends on psda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psda_div
  import psda_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_res_t      res
);
  logic [63:0] rem;
  logic [63:0] quot;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  // shift in the next dividend bit and test subtract
  always_comb begin
    trial = {rem, quot[63]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == 7'd1);
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quot <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!trial[64]) begin
          rem  <= trial[63:0];
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= {rem[62:0], quot[63]};
          quot <= {quot[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) busy <= 1'b0;
      end
    end
  end
  assign res = '{done: done, quot: quot};
endmodule
`default_nettype wire

// ===== hdl/phase_space_density_accumulator.sv =====
// Top level of the phase-space density accumulator.
// Uses psda_pkg and psda_div; weight table has a write port and a synchronous read port.
//
//  channel | handshake       | payload
//  in      | in_valid/stall  | req_t
//  out     | out_valid/stall | res_t
//  cfg     | cfg_valid/ready | cfg_index, cfg_data
//
// Table writes, start and skip requests are taken in the idle state. Every
// particle runs differences, squares and filters; one that passes then runs
// the bit-pair square root, the shared serial divide into the table position,
// and a table read and accumulate. A last particle adds the final divide.
// Reset is synchronous; the table is not cleared. A held result blocks new
// requests only when another must be sent.
`timescale 1ns / 1ps
`default_nettype none
module phase_space_density_accumulator
  import psda_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output res_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [39:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_D1, S_D2, S_D3, S_SQRT, S_DIV, S_RD, S_MUL, S_ACC, S_FDIV, S_FOUT
  } state_t;

  state_t state;
  logic [39:0] mom_radius_sq;
  logic [23:0] space_cutoff;
  logic [15:0] test_particles;

  logic signed [31:0] qpos [3];
  logic signed [31:0] qmom [3];
  logic [31:0] qspecies;
  logic [30:0] skip_ids [MaxSkip];
  logic [SkipCntW-1:0] skip_count;
  logic [47:0] density_sum;
  logic clipped;

  req_t cur;
  logic [32:0] dabs [6];
  logic [32:0] dmag [6];
  logic [65:0] sq [6];
  logic [63:0] msum, psum;
  logic keep;

  // square root state
  logic [63:0] sx, sres, sbit;
  logic [5:0]  scnt;

  logic p1_done;
  logic [TIdxW-1:0] tidx;
  logic [15:0] frac;
  logic [31:0] rd_data;
  logic [TIdxW-1:0] rd_addr;
  logic [48:0] p0, p1;

  logic [31:0] table_mem [TableSize];

  div_req_t dreq;
  div_res_t dres;
  psda_div u_div (.clk(clk), .rst(rst), .req(dreq), .res(dres));

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;

  // skip list match
  logic skip_hit;
  always_comb begin
    skip_hit = 1'b0;
    for (int k = 0; k < MaxSkip; k++)
      if (SkipCntW'(k) < skip_count && skip_ids[k] == cur.ident) skip_hit = 1'b1;
  end

  // magnitudes of the component differences
  always_comb begin
    for (int k = 0; k < 6; k++)
      dmag[k] = dabs[k][32] ? (~dabs[k] + 33'd1) : dabs[k];
  end

  // saturating sums of squares
  logic [64:0] t1, t2;
  always_comb begin
    t1 = {1'b0, sq[0][63:0]} + {1'b0, sq[1][63:0]};
    msum = (t1[64] | (|sq[0][65:64]) | (|sq[1][65:64])) ? '1 : t1[63:0];
    t2 = {1'b0, msum} + {1'b0, sq[2][63:0]};
    msum = (t2[64] | (|sq[2][65:64])) ? '1 : t2[63:0];
    t1 = {1'b0, sq[3][63:0]} + {1'b0, sq[4][63:0]};
    psum = (t1[64] | (|sq[3][65:64]) | (|sq[4][65:64])) ? '1 : t1[63:0];
    t2 = {1'b0, psum} + {1'b0, sq[5][63:0]};
    psum = (t2[64] | (|sq[5][65:64])) ? '1 : t2[63:0];
  end

  // particle filters
  always_comb begin
    keep = (cur.species == qspecies) && (msum <= 64'(mom_radius_sq)) &&
           (psum < 64'(space_cutoff) * 64'(space_cutoff)) && !skip_hit;
  end

  // square root step, one result bit per iteration from two radicand bits
  logic [63:0] s_trial;
  assign s_trial = sres + sbit;

  // table memory
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_data.cmd == CMD_WRITE &&
        in_data.ident < 31'(TableSize))
      table_mem[in_data.ident[TIdxW-1:0]] <= in_data.weight_value;
    rd_data <= table_mem[rd_addr];
  end

  // lower entry is read as the divide finishes, upper entry in the cycle after, during S_RD
  logic [TIdxW:0] tnext;
  assign tnext = {1'b0, tidx} + 1'b1;
  assign rd_addr = (state == S_DIV) ? dres.quot[TIdxW+15:16] : tnext[TIdxW-1:0];

  // accumulation and divider launch
  logic [48:0] acc;
  logic        div_pos, div_fin;
  logic [47:0] fin_sum;
  always_comb begin
    acc = {1'b0, density_sum} + 49'((p0 + p1) >> 16);
    div_pos = (state == S_MUL);
    div_fin = cur.last && ((state == S_D3 && !keep) || (state == S_ACC && p1_done));
    fin_sum = (state == S_ACC) ? (acc[48] ? 48'hFFFF_FFFF_FFFF : acc[47:0]) : density_sum;
  end

  always_ff @(posedge clk) begin
    dreq.start <= !rst && (div_pos || div_fin);
    if (div_pos) begin
      dreq.dividend <= sres * 64'(TableSize * 256);
      dreq.divisor <= 64'(space_cutoff);
    end else if (div_fin) begin
      dreq.dividend <= 64'(fin_sum);
      dreq.divisor <= (test_particles == 0) ? 64'd1 : 64'(test_particles);
    end
    if (rst) begin
      state <= S_IDLE;
      mom_radius_sq <= 40'd27487791;
      space_cutoff <= 24'd266076;
      test_particles <= 16'd20;
      for (int k = 0; k < 3; k++) begin
        qpos[k] <= '0;
        qmom[k] <= '0;
      end
      qspecies <= '0;
      for (int k = 0; k < MaxSkip; k++) skip_ids[k] <= '0;
      skip_count <= '0;
      density_sum <= '0;
      clipped <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MOM_RADIUS: mom_radius_sq <= cfg_data;
          REG_CUTOFF:     space_cutoff <= cfg_data[23:0];
          REG_TEST_PART:  test_particles <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            case (in_data.cmd)
              CMD_START: begin
                qpos[0] <= in_data.pos_x; qpos[1] <= in_data.pos_y;
                qpos[2] <= in_data.pos_z;
                qmom[0] <= in_data.mom_x; qmom[1] <= in_data.mom_y;
                qmom[2] <= in_data.mom_z;
                qspecies <= in_data.species;
                skip_count <= '0;
                density_sum <= '0;
                clipped <= 1'b0;
              end
              CMD_SKIP: begin
                if (skip_count < SkipCntW'(MaxSkip)) begin
                  skip_ids[skip_count[SkipIdxW-1:0]] <= in_data.ident;
                  skip_count <= skip_count + 1'b1;
                end
              end
              CMD_PART: state <= S_D1;
              default: ;
            endcase
          end
        end
        // signed component differences
        S_D1: begin
          dabs[0] <= ($signed({cur.mom_x[31], cur.mom_x}) - $signed({qmom[0][31], qmom[0]}));
          dabs[1] <= ($signed({cur.mom_y[31], cur.mom_y}) - $signed({qmom[1][31], qmom[1]}));
          dabs[2] <= ($signed({cur.mom_z[31], cur.mom_z}) - $signed({qmom[2][31], qmom[2]}));
          dabs[3] <= ($signed({cur.pos_x[31], cur.pos_x}) - $signed({qpos[0][31], qpos[0]}));
          dabs[4] <= ($signed({cur.pos_y[31], cur.pos_y}) - $signed({qpos[1][31], qpos[1]}));
          dabs[5] <= ($signed({cur.pos_z[31], cur.pos_z}) - $signed({qpos[2][31], qpos[2]}));
          state <= S_D2;
        end
        // squares of magnitudes
        S_D2: begin
          for (int k = 0; k < 6; k++) sq[k] <= 66'(dmag[k]) * 66'(dmag[k]);
          state <= S_D3;
        end
        // filters, then square root setup
        S_D3: begin
          sx <= psum << 16;
          sres <= '0;
          sbit <= 64'h4000_0000_0000_0000;
          scnt <= 6'd32;
          if (keep) state <= S_SQRT;
          else if (cur.last) state <= S_FDIV;
          else state <= S_IDLE;
        end
        S_SQRT: begin
          if (sx >= s_trial) begin
            sx <= sx - s_trial;
            sres <= (sres >> 1) + sbit;
          end else sres <= sres >> 1;
          sbit <= sbit >> 2;
          scnt <= scnt - 1'b1;
          if (scnt == 6'd1) begin
            state <= S_MUL;
          end
        end
        // divide of q * TableSize * 256 by the cutoff is launched here
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (dres.done) begin
            tidx <= dres.quot[TIdxW+15:16];
            frac <= dres.quot[15:0];
            if ((dres.quot >> 16) + 64'd1 >= 64'(TableSize)) begin
              state <= S_ACC;
              p0 <= '0; p1 <= '0;
              p1_done <= 1'b1;
            end else state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_ACC;
          p0 <= 49'(rd_data) * (49'd65536 - 49'(frac));
          p1_done <= 1'b0;
        end
        S_ACC: begin
          if (!p1_done) begin
            p1 <= 49'(rd_data) * 49'(frac);
            p1_done <= 1'b1;
          end else begin
            if (acc[48]) begin
              density_sum <= '1;
              clipped <= 1'b1;
            end else density_sum <= acc[47:0];
            if (cur.last) state <= S_FDIV;
            else state <= S_IDLE;
          end
        end
        S_FDIV: begin
          if (dres.done && !out_valid) begin
            out_valid <= 1'b1;
            out_data.density <= (|dres.quot[63:32]) ? '1 : dres.quot[31:0];
            out_data.saturated <= clipped | (|dres.quot[63:32]);
            density_sum <= '0;
            clipped <= 1'b0;
            state <= S_IDLE;
          end else if (dres.done) state <= S_FOUT;
        end
        // quotient held in the divider until the result register frees
        S_FOUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.density <= (|dres.quot[63:32]) ? '1 : dres.quot[31:0];
            out_data.saturated <= clipped | (|dres.quot[63:32]);
            density_sum <= '0;
            clipped <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
